### rtl/lslf_pkg.sv
`default_nettype none

package lslf_pkg;

	// Default sizing of the block.
	localparam int MAX_POINTS_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 24;

	// Fit status codes.
	localparam logic [1:0] FIT_OK      = 2'd0;
	localparam logic [1:0] FIT_NOSLOPE = 2'd1;
	localparam logic [1:0] FIT_FLAT    = 2'd2;
	localparam logic [1:0] FIT_DROPPED = 2'd3;

	// Saturation limits applied by the shared divider.
	localparam logic [63:0] CAP_POS32 = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] CAP_NEG32 = 64'h0000_0000_8000_0000;
	localparam logic [63:0] CAP_S64   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CAP_ONE   = 64'h0000_0000_0001_0000;

	// Divider geometry: a 64-bit magnitude shifted left by up to 17 places.
	localparam int DIV_BITS = 81;
	localparam logic [6:0] DIV_LAST = 7'd80;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DIVF,
		ST_LD_XX,
		ST_LD_END,
		ST_F_NUM1,
		ST_F_NUM2,
		ST_F_DEN1,
		ST_F_DEN2,
		ST_F_SLOPE,
		ST_F_SLOPE2,
		ST_F_INT,
		ST_F_INT2,
		ST_F_INT3,
		ST_F_MEAN,
		ST_F_RES0,
		ST_F_RES1,
		ST_F_RES2,
		ST_F_RES2B,
		ST_F_RES3,
		ST_F_RES4,
		ST_F_R2,
		ST_F_R2DONE,
		ST_F_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/lslf_ram.sv
`default_nettype none

module lslf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/least_squares_line_fit.sv
`default_nettype none

// Least-squares straight-line fit with coefficient of determination. Each input
// item is one (x, y) pair in signed Q8.16; the pair is stored and folded into
// running sums of x, y, x*y and x*x. The item with tlast set closes the set:
// the block then forms slope and intercept (Q16.16, saturated); when the slope
// is defined it walks the stored pairs a second time for the residual and total
// sums of squares. It sends one result item with intercept, slope, r-squared
// (Q1.16, 65536 is 1.0), a status code and the pair count. Status 1 means the
// slope is undefined (fewer than two distinct x values), 2 means all y values
// are equal, 3 means pairs beyond capacity were dropped; the lower code wins.
// All products run through one shared 32x32 multiplier, and all divisions
// through one restoring divider retiring one quotient bit per cycle (81
// quotient steps and one rounding step). A stored pair is folded in before the
// next item is accepted, while a pair arriving when the store is full is
// dropped without holding the input. When the slope is defined, r-squared is
// zero without a division if the total sum is zero or the residual sum is not
// below it. The second pass is limited by the shared multiplier, which forms
// three products per pair. The fit waits for the output register to be free
// before it hands over its result. The result sits in an output register, so
// a new set can start loading while it waits.
module least_squares_line_fit #(
	parameter int MAX_POINTS  = lslf_pkg::MAX_POINTS_DEF,
	parameter int SAMPLE_BITS = lslf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// x_value, y_value
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
	input  wire logic                                   s_tlast,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// intercept, slope, r_sq, fit_status, sample_count
	output logic [95:0]                                 m_tdata
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int DIV_W = lslf_pkg::DIV_BITS;
	localparam logic [63:0] ELIM = 64'(1) << (SAMPLE_BITS + 1);

	lslf_pkg::state_t state_q, state_d, ret_q;

	// Accumulated set.
	logic [63:0]   sum_x_q, sum_y_q, sum_xy_q, sum_xx_q;
	logic [CW-1:0] count_q;
	logic          ov_q;
	logic          last_q;

	// Shared multiplier.
	logic [63:0] mul_a_q, mul_b_q, prod_q, mul_res_q;
	logic [1:0]  mul_ph_q;
	logic [31:0] mul_opa, mul_opb;
	logic [63:0] mul_prod;

	// Shared divider.
	logic [DIV_W-1:0] div_num_q;
	logic [63:0] div_d_q, div_cap_q, div_rem_q, div_res_q;
	logic [65:0] div_quo_q;
	logic        div_sat_q;
	logic [6:0]  div_cnt_q;
	logic [64:0] div_rsh, div_rsub;
	logic        div_ge;
	logic [66:0] div_rnd;
	logic [63:0] div_fin;

	// Fit registers.
	logic [63:0]   x_q, y_q, tmp_q, num_q, mean_q, pred_q, dm_q, ss_res_q, ss_tot_q;
	logic          den_ok_q, neg_q;
	logic [31:0]   a_q, b_q;
	logic [16:0]   r2_q;
	logic [1:0]    status_q;
	logic [CW-1:0] idx_q;
	logic [95:0]   out_data_q;
	logic          out_valid_q;

	// Combinational helpers.
	logic [63:0] in_x, in_y, n64, den_c, t_c, b64, rd_x, rd_y;
	logic [63:0] num_mag, t_mag, sy_mag, pm, pr, ps, e_c, em, em_c, dv;
	logic [2*SAMPLE_BITS-1:0] rd_data;
	logic accept, full, ram_rd, out_free;

	assign in_x   = 64'(signed'(s_tdata[SAMPLE_BITS-1:0]));
	assign in_y   = 64'(signed'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
	assign rd_x   = 64'(signed'(rd_data[SAMPLE_BITS-1:0]));
	assign rd_y   = 64'(signed'(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]));
	assign n64    = 64'(count_q);
	assign b64    = 64'(signed'(b_q));
	assign full   = (count_q == CW'(MAX_POINTS));
	assign accept = s_tvalid && s_tready;
	assign ram_rd = (state_q == lslf_pkg::ST_F_RES0);
	assign out_free = !out_valid_q || m_tready;

	assign s_tready = (state_q == lslf_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Products and differences used by the fit sequencer.
	assign den_c   = tmp_q - mul_res_q;
	assign num_mag = num_q[63] ? -num_q : num_q;
	assign t_c     = (sum_y_q << 16) - mul_res_q;
	assign t_mag   = t_c[63] ? -t_c : t_c;
	assign sy_mag  = sum_y_q[63] ? -sum_y_q : sum_y_q;
	// Prediction term b*x / 65536, rounded half away from zero.
	assign pm   = mul_res_q[63] ? -mul_res_q : mul_res_q;
	assign pr   = (pm + 64'd32768) >> 16;
	assign ps   = mul_res_q[63] ? -pr : pr;
	assign e_c  = y_q - pred_q;
	assign em   = e_c[63] ? -e_c : e_c;
	assign em_c = (em > ELIM) ? ELIM : em;
	assign dv   = y_q - mean_q;

	lslf_ram #(
		.WIDTH(2*SAMPLE_BITS),
		.DEPTH(MAX_POINTS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (accept && !full),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(s_tdata[2*SAMPLE_BITS-1:0]),
		.rd_en  (ram_rd),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// One 32x32 multiplier: low*low, low*high, high*low give a product mod 2^64.
	assign mul_opa  = (mul_ph_q == 2'd2) ? mul_a_q[63:32] : mul_a_q[31:0];
	assign mul_opb  = (mul_ph_q == 2'd1) ? mul_b_q[63:32] : mul_b_q[31:0];
	assign mul_prod = mul_opa * mul_opb;

	// Restoring divider step and final rounding with saturation.
	assign div_rsh  = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_ge   = (div_rsh >= {1'b0, div_d_q});
	assign div_rsub = div_rsh - {1'b0, div_d_q};
	assign div_rnd  = ({1'b0, div_quo_q} + 67'd1) >> 1;
	assign div_fin  = (div_sat_q || div_rnd > {3'b0, div_cap_q}) ? div_cap_q
		: div_rnd[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lslf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lslf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (!full) begin
						state_d = lslf_pkg::ST_MUL;
					end else if (s_tlast) begin
						state_d = lslf_pkg::ST_F_NUM1;
					end
				end
			end
			lslf_pkg::ST_MUL: begin
				if (mul_ph_q == 2'd3) begin
					state_d = ret_q;
				end
			end
			lslf_pkg::ST_DIV: begin
				if (div_cnt_q == lslf_pkg::DIV_LAST) begin
					state_d = lslf_pkg::ST_DIVF;
				end
			end
			lslf_pkg::ST_DIVF:   state_d = ret_q;
			lslf_pkg::ST_LD_XX:  state_d = lslf_pkg::ST_MUL;
			lslf_pkg::ST_LD_END: state_d = last_q ? lslf_pkg::ST_F_NUM1 : lslf_pkg::ST_IDLE;
			lslf_pkg::ST_F_NUM1, lslf_pkg::ST_F_NUM2, lslf_pkg::ST_F_DEN1,
			lslf_pkg::ST_F_DEN2, lslf_pkg::ST_F_INT, lslf_pkg::ST_F_RES1,
			lslf_pkg::ST_F_RES2B, lslf_pkg::ST_F_RES3: begin
				state_d = lslf_pkg::ST_MUL;
			end
			lslf_pkg::ST_F_SLOPE: begin
				state_d = (!den_c[63] && den_c != 64'd0) ? lslf_pkg::ST_DIV
					: lslf_pkg::ST_F_INT;
			end
			lslf_pkg::ST_F_SLOPE2: state_d = lslf_pkg::ST_F_INT;
			lslf_pkg::ST_F_INT2:   state_d = lslf_pkg::ST_DIV;
			lslf_pkg::ST_F_INT3: begin
				state_d = den_ok_q ? lslf_pkg::ST_DIV : lslf_pkg::ST_F_DONE;
			end
			lslf_pkg::ST_F_MEAN: state_d = lslf_pkg::ST_F_RES0;
			lslf_pkg::ST_F_RES0: state_d = lslf_pkg::ST_F_RES1;
			lslf_pkg::ST_F_RES2: state_d = lslf_pkg::ST_F_RES2B;
			lslf_pkg::ST_F_RES4: begin
				state_d = (idx_q + CW'(1) == count_q) ? lslf_pkg::ST_F_R2
					: lslf_pkg::ST_F_RES0;
			end
			lslf_pkg::ST_F_R2: begin
				if (ss_tot_q != 64'd0 && ss_res_q < ss_tot_q) begin
					state_d = lslf_pkg::ST_DIV;
				end else begin
					state_d = lslf_pkg::ST_F_DONE;
				end
			end
			lslf_pkg::ST_F_R2DONE: state_d = lslf_pkg::ST_F_DONE;
			lslf_pkg::ST_F_DONE: begin
				if (out_free) begin
					state_d = lslf_pkg::ST_IDLE;
				end
			end
			default: state_d = lslf_pkg::ST_IDLE;
		endcase
	end

	// Set state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_xy_q    <= '0;
			sum_xx_q    <= '0;
			count_q     <= '0;
			ov_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == lslf_pkg::ST_F_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lslf_pkg::ST_IDLE: begin
					if (accept) begin
						if (!full) begin
							sum_x_q <= sum_x_q + in_x;
							sum_y_q <= sum_y_q + in_y;
							count_q <= count_q + CW'(1);
						end else begin
							ov_q <= 1'b1;
						end
					end
				end
				lslf_pkg::ST_LD_XX:  sum_xy_q <= sum_xy_q + mul_res_q;
				lslf_pkg::ST_LD_END: sum_xx_q <= sum_xx_q + mul_res_q;
				lslf_pkg::ST_F_DONE: begin
					if (out_free) begin
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						sum_xy_q    <= '0;
						sum_xx_q    <= '0;
						count_q     <= '0;
						ov_q        <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath of the sequencer: operand loading, shared units and fit values.
	always_ff @(posedge clk) begin
		case (state_q)
			lslf_pkg::ST_IDLE: begin
				if (accept) begin
					x_q      <= in_x;
					y_q      <= in_y;
					last_q   <= s_tlast;
					mul_a_q  <= in_x;
					mul_b_q  <= in_y;
					mul_ph_q <= 2'd0;
					ret_q    <= lslf_pkg::ST_LD_XX;
				end
			end
			lslf_pkg::ST_MUL: begin
				prod_q   <= mul_prod;
				mul_ph_q <= mul_ph_q + 2'd1;
				case (mul_ph_q)
					2'd0:    mul_res_q <= mul_res_q;
					2'd1:    mul_res_q <= prod_q;
					default: mul_res_q <= mul_res_q + {prod_q[31:0], 32'd0};
				endcase
			end
			lslf_pkg::ST_DIV: begin
				div_num_q <= div_num_q << 1;
				div_rem_q <= div_ge ? div_rsub[63:0] : div_rsh[63:0];
				div_quo_q <= {div_quo_q[64:0], div_ge};
				div_sat_q <= div_sat_q | div_quo_q[65];
				div_cnt_q <= div_cnt_q + 7'd1;
			end
			lslf_pkg::ST_DIVF: div_res_q <= div_fin;
			lslf_pkg::ST_LD_XX: begin
				mul_a_q  <= x_q;
				mul_b_q  <= x_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_LD_END;
			end
			lslf_pkg::ST_F_NUM1: begin
				mul_a_q  <= n64;
				mul_b_q  <= sum_xy_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_NUM2;
			end
			lslf_pkg::ST_F_NUM2: begin
				tmp_q    <= mul_res_q;
				mul_a_q  <= sum_x_q;
				mul_b_q  <= sum_y_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_DEN1;
			end
			lslf_pkg::ST_F_DEN1: begin
				num_q    <= tmp_q - mul_res_q;
				mul_a_q  <= n64;
				mul_b_q  <= sum_xx_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_DEN2;
			end
			lslf_pkg::ST_F_DEN2: begin
				tmp_q    <= mul_res_q;
				mul_a_q  <= sum_x_q;
				mul_b_q  <= sum_x_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_SLOPE;
			end
			lslf_pkg::ST_F_SLOPE: begin
				den_ok_q  <= !den_c[63] && den_c != 64'd0;
				b_q       <= 32'd0;
				neg_q     <= num_q[63];
				div_num_q <= {17'd0, num_mag} << 17;
				div_d_q   <= den_c;
				div_cap_q <= num_q[63] ? lslf_pkg::CAP_NEG32 : lslf_pkg::CAP_POS32;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_sat_q <= 1'b0;
				div_cnt_q <= '0;
				ret_q     <= lslf_pkg::ST_F_SLOPE2;
			end
			lslf_pkg::ST_F_SLOPE2: begin
				b_q <= neg_q ? 32'(-div_res_q) : div_res_q[31:0];
			end
			lslf_pkg::ST_F_INT: begin
				mul_a_q  <= b64;
				mul_b_q  <= sum_x_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_INT2;
			end
			lslf_pkg::ST_F_INT2: begin
				neg_q     <= t_c[63];
				div_num_q <= {17'd0, t_mag} << 1;
				div_d_q   <= n64 << 16;
				div_cap_q <= t_c[63] ? lslf_pkg::CAP_NEG32 : lslf_pkg::CAP_POS32;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_sat_q <= 1'b0;
				div_cnt_q <= '0;
				ret_q     <= lslf_pkg::ST_F_INT3;
			end
			lslf_pkg::ST_F_INT3: begin
				a_q       <= neg_q ? 32'(-div_res_q) : div_res_q[31:0];
				status_q  <= lslf_pkg::FIT_NOSLOPE;
				r2_q      <= '0;
				neg_q     <= sum_y_q[63];
				div_num_q <= {17'd0, sy_mag} << 1;
				div_d_q   <= n64;
				div_cap_q <= lslf_pkg::CAP_S64;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_sat_q <= 1'b0;
				div_cnt_q <= '0;
				ret_q     <= lslf_pkg::ST_F_MEAN;
			end
			lslf_pkg::ST_F_MEAN: begin
				mean_q   <= neg_q ? -div_res_q : div_res_q;
				idx_q    <= '0;
				ss_res_q <= '0;
				ss_tot_q <= '0;
			end
			lslf_pkg::ST_F_RES1: begin
				y_q      <= rd_y;
				mul_a_q  <= b64;
				mul_b_q  <= rd_x;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_RES2;
			end
			lslf_pkg::ST_F_RES2: begin
				pred_q <= 64'(signed'(a_q)) + ps;
				dm_q   <= dv[63] ? -dv : dv;
			end
			lslf_pkg::ST_F_RES2B: begin
				mul_a_q  <= em_c;
				mul_b_q  <= em_c;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_RES3;
			end
			lslf_pkg::ST_F_RES3: begin
				ss_res_q <= ss_res_q + mul_res_q;
				mul_a_q  <= dm_q;
				mul_b_q  <= dm_q;
				mul_ph_q <= 2'd0;
				ret_q    <= lslf_pkg::ST_F_RES4;
			end
			lslf_pkg::ST_F_RES4: begin
				ss_tot_q <= ss_tot_q + mul_res_q;
				idx_q    <= idx_q + CW'(1);
			end
			lslf_pkg::ST_F_R2: begin
				r2_q      <= '0;
				status_q  <= (ss_tot_q == 64'd0) ? lslf_pkg::FIT_FLAT
					: (ov_q ? lslf_pkg::FIT_DROPPED : lslf_pkg::FIT_OK);
				div_num_q <= {17'd0, ss_tot_q - ss_res_q} << 17;
				div_d_q   <= ss_tot_q;
				div_cap_q <= lslf_pkg::CAP_ONE;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_sat_q <= 1'b0;
				div_cnt_q <= '0;
				ret_q     <= lslf_pkg::ST_F_R2DONE;
			end
			lslf_pkg::ST_F_R2DONE: r2_q <= div_res_q[16:0];
			lslf_pkg::ST_F_DONE: begin
				if (out_free) begin
					out_data_q <= {6'd0, n64[6:0], status_q, r2_q, b_q, a_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### test/least_squares_line_fit_test.sv
`default_nettype none

// Testbench for the least-squares line fit. Pair items are streamed in directed
// sets and in random-length sets, each closed by an item with tlast set. A
// scoreboard object keeps its own copy of the sums and the pair store, works out
// the expected fit for every closing item and checks each result item field by field.
module least_squares_line_fit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS  = lslf_pkg::MAX_POINTS_DEF;
	localparam int SBITS = lslf_pkg::SAMPLE_BITS_DEF;
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct packed {
		logic [6:0]         count;
		logic [1:0]         status;
		logic [16:0]        r_sq;
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
	} fit_t;

	typedef struct {
		logic signed [SBITS-1:0] x;
		logic signed [SBITS-1:0] y;
		bit                      last;
	} pair_t;

	// Predicts the fit of each closed set and matches the result items against it.
	class fit_scoreboard;
		longint  px[NPTS];
		longint  py[NPTS];
		longint unsigned acc_x, acc_y, acc_xy, acc_xx;
		int      n_stored;
		bit      dropped;
		fit_t    pending[$];
		int      mismatches;
		int      checked;
		int      status_seen[4];

		function new();
			clear_set();
			mismatches = 0;
			checked = 0;
		endfunction

		function void clear_set();
			acc_x = 0;
			acc_y = 0;
			acc_xy = 0;
			acc_xx = 0;
			n_stored = 0;
			dropped = 0;
		endfunction

		static function longint unsigned magn(longint v);
			return v < 0 ? 64'd0 - longint'(v) : longint'(v);
		endfunction

		// Rounded a * 2^fb / d, ties away from zero, limited to cap.
		static function longint unsigned round_div(longint unsigned a, longint unsigned d,
				int fb, longint unsigned cap);
			longint unsigned q, r;
			bit b;
			q = a / d;
			r = a % d;
			if (q > (cap >> fb))
				return cap;
			for (int i = 0; i <= fb; i++) begin
				b = r >= d - r;
				r = b ? r - (d - r) : r + r;
				q = (q << 1) | longint'(b);
			end
			q = (q + 1) >> 1;
			return q > cap ? cap : q;
		endfunction

		static function longint div_sat32(longint num, longint unsigned d, int fb);
			if (num < 0)
				return -longint'(round_div(magn(num), d, fb, lslf_pkg::CAP_NEG32));
			return longint'(round_div(magn(num), d, fb, lslf_pkg::CAP_POS32));
		endfunction

		static function longint div_round(longint num, longint unsigned d);
			longint unsigned m;
			m = round_div(magn(num), d, 0, lslf_pkg::CAP_S64);
			return num < 0 ? -longint'(m) : longint'(m);
		endfunction

		// Folds one accepted pair item in; a closing item yields one expected fit.
		function void note_pair(logic [SBITS-1:0] xr, logic [SBITS-1:0] yr, bit last);
			longint x, y, num, den, b, a, mean, pred;
			longint unsigned n, ss_res, ss_tot, em, dm, elim;
			fit_t f;
			x = longint'(signed'(xr));
			y = longint'(signed'(yr));
			if (n_stored < NPTS) begin
				px[n_stored] = x;
				py[n_stored] = y;
				n_stored++;
				acc_x += x;
				acc_y += y;
				acc_xy += x * y;
				acc_xx += x * x;
			end else begin
				dropped = 1;
			end
			if (!last)
				return;
			n = n_stored;
			num = longint'(n * acc_xy - acc_x * acc_y);
			den = longint'(n * acc_xx - acc_x * acc_x);
			b = 0;
			if (den > 0)
				b = div_sat32(num, den, 16);
			a = div_sat32(longint'(acc_y * 65536 - longint'(b) * acc_x), n * 65536, 0);
			f.r_sq = '0;
			if (den <= 0) begin
				f.status = lslf_pkg::FIT_NOSLOPE;
			end else begin
				// Residuals are clamped in magnitude before squaring.
				elim = 64'd1 << (SBITS + 1);
				mean = div_round(longint'(acc_y), n);
				ss_res = 0;
				ss_tot = 0;
				for (int i = 0; i < n_stored; i++) begin
					pred = a + div_round(b * px[i], 65536);
					em = magn(py[i] - pred);
					dm = magn(py[i] - mean);
					if (em > elim)
						em = elim;
					ss_res += em * em;
					ss_tot += dm * dm;
				end
				if (ss_tot == 0) begin
					f.status = lslf_pkg::FIT_FLAT;
				end else begin
					if (ss_res < ss_tot)
						f.r_sq = 17'(round_div(ss_tot - ss_res, ss_tot, 16,
							lslf_pkg::CAP_ONE));
					f.status = dropped ? lslf_pkg::FIT_DROPPED : lslf_pkg::FIT_OK;
				end
			end
			f.intercept = a[31:0];
			f.slope = b[31:0];
			f.count = n[6:0];
			pending.insert(pending.size(), f);
			clear_set();
		endfunction

		function void check_fit(logic [95:0] word);
			fit_t got, want;
			got = word[$bits(fit_t)-1:0];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", word);
				return;
			end
			want = pending.pop_front();
			checked++;
			status_seen[want.status]++;
			if (got !== want || word[95:$bits(fit_t)] !== '0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("fit %0d: exp a=%0d b=%0d r2=%0d st=%0d n=%0d,",
						checked, want.intercept, want.slope, want.r_sq, want.status,
						want.count);
					$display("    got a=%0d b=%0d r2=%0d st=%0d n=%0d",
						got.intercept, got.slope, got.r_sq, got.status, got.count);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;

	fit_scoreboard sb = new();
	pair_t         stim[$];
	int            pairs_accepted = 0;
	int            cycle_count = 0;
	int            sets_sent = 0;

	least_squares_line_fit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both handshakes are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_pair(s_tdata[SBITS-1:0], s_tdata[2*SBITS-1:SBITS], s_tlast);
			pairs_accepted++;
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check_fit(m_tdata);
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic signed [SBITS-1:0] clamp24(longint v);
		if (v > 8388607)
			return 24'sh7FFFFF;
		if (v < -8388608)
			return 24'sh800000;
		return v[SBITS-1:0];
	endfunction

	function automatic void add_pair(longint x, longint y, bit last);
		pair_t p;
		p.x = clamp24(x);
		p.y = clamp24(y);
		p.last = last;
		stim.insert(stim.size(), p);
	endfunction

	// Directed sets: extremes, a single pair, one distinct x, flat y and a slope
	// that saturates.
	function automatic void build_directed();
		add_pair(-8388608, 8388607, 1);
		add_pair(8388607, -8388608, 0);
		add_pair(8388607, 8388607, 1);
		add_pair(-8388608, -8388608, 0);
		add_pair(8388607, 8388607, 0);
		add_pair(-8388608, 8388607, 0);
		add_pair(8388607, -8388608, 1);
		add_pair(12345, 100, 0);
		add_pair(12345, -100, 0);
		add_pair(12345, 7, 1);
		add_pair(-5000, 65536, 0);
		add_pair(0, 65536, 0);
		add_pair(70000, 65536, 1);
		add_pair(0, -8388608, 0);
		add_pair(1, 8388607, 1);
		add_pair(1, -8388608, 0);
		add_pair(0, 8388607, 1);
		add_pair(-65536, -131072, 0);
		add_pair(0, 0, 0);
		add_pair(65536, 131072, 0);
		add_pair(131072, 262144, 1);
		sets_sent = 8;
	endfunction

	// Random sets, mostly short, some filling the store and some running past it.
	function automatic void build_random();
		int len, kind, nitems;
		longint x, y, k, c, noise, x0;
		nitems = 0;
		while (nitems < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 60)
				len = $urandom_range(2, 16);
			else if (kind < 70)
				len = $urandom_range(1, 4);
			else if (kind < 85)
				len = $urandom_range(NPTS - 3, NPTS + 6);
			else
				len = $urandom_range(3, 30);
			k = $signed($urandom_range(0, 16)) - 8;
			c = $signed($urandom_range(0, 2000000)) - 1000000;
			noise = 1 << $urandom_range(0, 20);
			x0 = $signed($urandom_range(0, 2000000)) - 1000000;
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 3))
					0: x = longint'(signed'($urandom()) >>> 8);
					1: x = (kind >= 60 && kind < 70) ? x0 : x0 + i * 4096;
					default: x = $signed($urandom_range(0, 2097152)) - 1048576;
				endcase
				if (kind >= 95)
					y = c;
				else if ($urandom_range(0, 4) == 0)
					y = longint'(signed'($urandom()) >>> 8);
				else
					y = k * x / 2 + c + ($signed($urandom_range(0, 2 * noise)) - noise);
				add_pair(x, y, i == len - 1);
			end
			nitems += len;
			sets_sent++;
		end
	endfunction

	// Sends one pair item and returns at the falling edge after it was taken.
	task automatic send_pair(pair_t p);
		int seen;
		seen = pairs_accepted;
		s_tdata <= {p.y, p.x};
		s_tlast <= p.last;
		s_tvalid <= 1'b1;
		do
			@(negedge clk);
		while (pairs_accepted == seen);
	endtask

	// The sender works in bursts of random length with random gaps in between.
	task automatic drive_all();
		int burst;
		burst = 0;
		foreach (stim[i]) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 30)) @(negedge clk);
				end
			end
			burst--;
			send_pair(stim[i]);
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
	endtask

	// Receiver stall pattern: a random mode for each random-length stretch, and once
	// the receiver holds off long enough for the block to back up its input.
	initial begin
		int mode, left, hold;
		mode = 0;
		left = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold == 0 && pairs_accepted >= 400 && pairs_accepted < 410)
				hold = 6000;
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(50, 400);
			end
			left--;
			if (hold > 1) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		int waited;
		build_directed();
		build_random();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		drive_all();
		// The wait covers the fit of a full set plus the receiver stall.
		waited = 0;
		while (sb.pending.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (3000) @(negedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0d expected results never arrived", sb.pending.size());
			sb.mismatches += sb.pending.size();
		end
		$display("Sent %0d pair items in %0d sets; checked %0d fits in %0d cycles.",
			pairs_accepted, sets_sent, sb.checked, cycle_count);
		$display("Status mix ok/noslope/flat/dropped: %0d/%0d/%0d/%0d, mismatches %0d.",
			sb.status_seen[lslf_pkg::FIT_OK], sb.status_seen[lslf_pkg::FIT_NOSLOPE],
			sb.status_seen[lslf_pkg::FIT_FLAT], sb.status_seen[lslf_pkg::FIT_DROPPED],
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

`default_nettype wire

### least_squares_line_fit.f
rtl/lslf_pkg.sv
rtl/lslf_ram.sv
rtl/least_squares_line_fit.sv
test/least_squares_line_fit_test.sv
